// ----- design/frame_animation_sequencer_defines.svh -----
// Assertion macros for the frame animation sequencer checker.
// Needs i_clk and i_rst_n in the scope where the macros are used.
`ifndef FRAME_ANIMATION_SEQUENCER_DEFINES_SVH
`define FRAME_ANIMATION_SEQUENCER_DEFINES_SVH

// Check cons in the same cycle as ante, outside reset.
`define FAS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check cons in the cycle after ante, outside reset.
`define FAS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/fas_pkg.sv -----
// Shared types, codes and step helpers for the frame animation sequencer.
// No dependencies; the search, datapath, controller and top-level files import this package.
package fas_pkg;

    localparam int FRAMES_DEF = 31;

    typedef logic [4:0]  t_frame;
    typedef logic [15:0] t_dwell;

    // request kinds
    localparam logic [3:0] KIND_TICK      = 4'd0;
    localparam logic [3:0] KIND_HIDE      = 4'd1;
    localparam logic [3:0] KIND_STOP      = 4'd2;
    localparam logic [3:0] KIND_STEP_FWD  = 4'd3;
    localparam logic [3:0] KIND_STEP_BACK = 4'd4;
    localparam logic [3:0] KIND_LOOP_FWD  = 4'd5;
    localparam logic [3:0] KIND_LOOP_BACK = 4'd6;
    localparam logic [3:0] KIND_ROCK      = 4'd7;
    localparam logic [3:0] KIND_FIRST     = 4'd8;
    localparam logic [3:0] KIND_LAST      = 4'd9;
    localparam logic [3:0] KIND_CURRENT   = 4'd10;

    // configuration register indexes
    localparam logic [2:0] REG_FRAME_COUNT  = 3'd0;
    localparam logic [2:0] REG_START_FRAME  = 3'd1;
    localparam logic [2:0] REG_DWELL_FIRST  = 3'd2;
    localparam logic [2:0] REG_DWELL_MIDDLE = 3'd3;
    localparam logic [2:0] REG_DWELL_LAST   = 3'd4;
    localparam logic [2:0] REG_BAD_FRAMES   = 3'd5;
    localparam logic [2:0] REG_ALL_BAD      = 3'd6;

    // loop modes
    localparam logic [1:0] MODE_NONE = 2'd0;
    localparam logic [1:0] MODE_FWD  = 2'd1;
    localparam logic [1:0] MODE_BACK = 2'd2;
    localparam logic [1:0] MODE_ROCK = 2'd3;

    // search start selects
    localparam logic [1:0] SEL_FIRST = 2'd0;
    localparam logic [1:0] SEL_LAST  = 2'd1;
    localparam logic [1:0] SEL_NEXT  = 2'd2;
    localparam logic [1:0] SEL_CMD   = 2'd3;

    localparam t_dwell DEFAULT_DWELL = 16'd100;
    localparam t_dwell START_DWELL   = 16'd1;

    typedef struct packed {
        logic       latch;
        logic       cfg_we;
        logic       srch_start;
        logic [1:0] srch_sel;
        logic       save_first;
        logic       save_last;
        logic       save_index;
        logic       decide;
        logic       finish;
    } t_dp_cmd;

    typedef struct packed {
        logic drop;
        logic direct;
        logic tick;
        logic srch_done;
        logic n_zero;
        logic out_free;
    } t_dp_stat;

    function automatic t_frame clamp_frames(input t_frame fc, input t_frame lim);
        return (fc > lim) ? lim : fc;
    endfunction

    function automatic t_frame total_of(input t_frame num);
        return (num == 5'd0) ? 5'd1 : num;
    endfunction

    function automatic t_frame step_fwd(input t_frame p, input t_frame num);
        logic [5:0] s;
        s = {1'b0, p} + 6'd1;
        return (s > {1'b0, num}) ? 5'(s - {1'b0, total_of(num)}) : s[4:0];
    endfunction

    function automatic t_frame step_back(input t_frame p, input t_frame num);
        t_frame lim;
        lim = (num != 5'd0) ? 5'd2 : 5'd1;
        return (p < lim) ? 5'({1'b0, p} + {1'b0, total_of(num)} - 6'd1) : (p - 5'd1);
    endfunction

endpackage

// ----- design/fas_search.sv -----
// Bounded circular search for the next frame not flagged bad, one probe a cycle.
// Depends on fas_pkg.
module fas_search #(
    parameter int FRAMES = fas_pkg::FRAMES_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  fas_pkg::t_frame i_start_frame,
    input  logic            i_back,
    input  fas_pkg::t_frame i_num,
    input  logic [31:0]     i_bad,
    output logic            o_done,
    output fas_pkg::t_frame o_found
);
    import fas_pkg::*;

    localparam int               CNT_W    = $clog2(FRAMES + 1);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(FRAMES);

    logic             r_busy;
    t_frame           r_probe;
    logic             r_back;
    logic [CNT_W-1:0] r_cnt;
    logic             w_good;

    assign w_good  = !i_bad[r_probe];
    assign o_done  = r_busy && (w_good || (r_cnt == CNT_LAST));
    assign o_found = w_good ? r_probe : 5'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (o_done) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            // saturate the start index to the loop length
            r_probe <= (i_start_frame > i_num) ? i_num : i_start_frame;
            r_back  <= i_back;
            r_cnt   <= '0;
        end else if (r_busy && !o_done) begin
            r_probe <= r_back ? step_back(r_probe, i_num) : step_fwd(r_probe, i_num);
            r_cnt   <= r_cnt + 1'b1;
        end
    end

endmodule

// ----- design/fas_datapath.sv -----
// Datapath: configuration, sequencer state, dwell choice and the output register.
// Depends on fas_pkg and fas_search.
module fas_datapath #(
    parameter int FRAMES = fas_pkg::FRAMES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  fas_pkg::t_dp_cmd  i_cmd,
    output fas_pkg::t_dp_stat o_stat,
    input  logic [3:0]        i_s_tuser,
    input  logic [7:0]        i_s_tdata,
    input  logic [2:0]        i_cfg_index,
    input  logic [31:0]       i_cfg_data,
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output logic [31:0]       o_m_tdata
);
    import fas_pkg::*;

    localparam t_frame FRAME_LIM = (FRAMES > 31) ? 5'd31 : 5'(FRAMES);

    // configuration
    t_frame      r_frame_count;
    t_frame      r_start_frame;
    t_dwell      r_dwell_first;
    t_dwell      r_dwell_middle;
    t_dwell      r_dwell_last;
    logic [31:0] r_bad_frames;
    logic        r_all_bad;
    logic        r_configured;

    // sequencer state
    t_frame      r_frame_index;
    t_frame      r_saved_index;
    t_frame      r_shown;
    logic        r_dir_back;
    logic [1:0]  r_loop_mode;
    logic        r_hidden;
    logic        r_running;

    // request and working values
    logic [3:0]  r_kind;
    logic        r_at_cur;
    t_frame      r_first;
    t_frame      r_last;
    t_frame      r_ipxm;
    t_dwell      r_dwell;
    logic        r_m_valid;
    logic [31:0] r_m_data;

    t_frame      w_num;
    t_frame      w_total;
    t_frame      w_fst;
    logic        w_is_tick;
    logic        w_is_loop;
    logic        w_srch_done;
    t_frame      w_found;

    // setup values on a frame_count or start_frame write
    t_frame      w_new_fc;
    t_frame      w_new_sf;
    t_frame      w_new_num;
    t_frame      w_setup_idx;

    // tick decision
    logic        w_tick_dir;
    t_dwell      w_tick_dwell;

    // search launch
    logic        w_keep;
    logic        w_loop_dir;
    t_frame      w_cmd_start;
    logic        w_cmd_back;
    t_frame      w_srch_start;
    logic        w_srch_back;

    // values committed at the end of a request
    t_frame      n_frame_out;
    t_dwell      n_dwell_out;
    logic        n_running;
    logic        n_hidden;
    logic [1:0]  n_loop_mode;

    assign w_num     = clamp_frames(r_frame_count, FRAME_LIM);
    assign w_total   = total_of(w_num);
    assign w_fst     = {4'd0, w_num != 5'd0};
    assign w_is_tick = (r_kind == KIND_TICK);

    always_comb begin
        w_is_loop = r_kind inside {KIND_LOOP_FWD, KIND_LOOP_BACK, KIND_ROCK};
    end

    assign o_stat.drop      = !r_configured || (r_kind > KIND_CURRENT) ||
                              (w_is_tick && !r_running);
    assign o_stat.direct    = r_all_bad || (r_kind == KIND_HIDE);
    assign o_stat.tick      = w_is_tick;
    assign o_stat.srch_done = w_srch_done;
    assign o_stat.n_zero    = (w_num == 5'd0);
    assign o_stat.out_free  = !r_m_valid || i_m_tready;

    assign w_new_fc    = (i_cfg_index == REG_FRAME_COUNT) ? i_cfg_data[4:0] : r_frame_count;
    assign w_new_sf    = (i_cfg_index == REG_START_FRAME) ? i_cfg_data[4:0] : r_start_frame;
    assign w_new_num   = clamp_frames(w_new_fc, FRAME_LIM);
    assign w_setup_idx = (w_new_sf >= 5'd1 && w_new_sf <= w_new_num) ? w_new_sf : 5'd0;

    // dwell and direction from the position against the two ends of the loop
    always_comb begin
        w_tick_dir   = r_dir_back;
        w_tick_dwell = DEFAULT_DWELL;
        case (r_loop_mode)
            MODE_FWD: begin
                w_tick_dir   = 1'b0;
                w_tick_dwell = (r_frame_index == r_first) ? r_dwell_first :
                               (r_frame_index == r_last)  ? r_dwell_last  : r_dwell_middle;
            end
            MODE_BACK: begin
                w_tick_dir   = 1'b1;
                w_tick_dwell = (r_frame_index == r_first) ? r_dwell_last  :
                               (r_frame_index == r_last)  ? r_dwell_first : r_dwell_middle;
            end
            MODE_ROCK: begin
                if (r_frame_index == r_first) begin
                    w_tick_dir = 1'b0;
                end else if (r_frame_index == r_last) begin
                    w_tick_dir = 1'b1;
                end
                w_tick_dwell = (r_frame_index == r_first || r_frame_index == r_last) ?
                               r_dwell_last : r_dwell_middle;
            end
            default: begin
                w_tick_dwell = DEFAULT_DWELL;
            end
        endcase
    end

    assign w_keep     = r_at_cur && ((r_kind == KIND_LOOP_BACK) ? (r_shown != w_fst) :
                                                               (r_shown != w_num));
    assign w_loop_dir = w_keep ? r_dir_back : (r_kind == KIND_LOOP_BACK);

    always_comb begin
        case (r_kind)
            KIND_STOP: begin
                w_cmd_start = r_at_cur ? r_shown : w_num;
                w_cmd_back  = !r_at_cur;
            end
            KIND_STEP_FWD: begin
                w_cmd_start = step_fwd(r_frame_index, w_num);
                w_cmd_back  = 1'b0;
            end
            KIND_STEP_BACK: begin
                w_cmd_start = step_back(r_frame_index, w_num);
                w_cmd_back  = 1'b1;
            end
            KIND_LOOP_FWD, KIND_LOOP_BACK, KIND_ROCK: begin
                w_cmd_start = w_keep ? r_shown : (w_loop_dir ? w_num : w_fst);
                w_cmd_back  = w_loop_dir;
            end
            KIND_FIRST: begin
                w_cmd_start = w_fst;
                w_cmd_back  = 1'b0;
            end
            KIND_LAST: begin
                w_cmd_start = w_num;
                w_cmd_back  = 1'b1;
            end
            default: begin
                w_cmd_start = r_frame_index;
                w_cmd_back  = 1'b0;
            end
        endcase
    end

    always_comb begin
        case (i_cmd.srch_sel)
            SEL_FIRST: begin
                w_srch_start = w_fst;
                w_srch_back  = 1'b0;
            end
            SEL_LAST: begin
                w_srch_start = w_num;
                w_srch_back  = 1'b1;
            end
            SEL_NEXT: begin
                w_srch_start = w_tick_dir ? step_back(r_frame_index, w_num) :
                                            step_fwd(r_frame_index, w_num);
                w_srch_back  = w_tick_dir;
            end
            default: begin
                w_srch_start = w_cmd_start;
                w_srch_back  = w_cmd_back;
            end
        endcase
    end

    fas_search #(
        .FRAMES (FRAMES)
    ) u_search (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (i_cmd.srch_start),
        .i_start_frame (w_srch_start),
        .i_back        (w_srch_back),
        .i_num         (w_num),
        .i_bad         (r_bad_frames),
        .o_done        (w_srch_done),
        .o_found       (w_found)
    );

    always_comb begin
        n_loop_mode = w_is_tick ? r_loop_mode :
                      (w_is_loop ? 2'(r_kind - KIND_STEP_BACK) : MODE_NONE);
        n_running   = r_running;
        if (r_kind == KIND_STOP) begin
            n_running = 1'b0;
        end else if (w_is_loop && !r_all_bad && w_total > 5'd1) begin
            n_running = 1'b1;
        end
        if (w_is_tick) begin
            n_hidden = r_hidden;
        end else if (r_kind == KIND_HIDE) begin
            n_hidden = r_all_bad ? r_hidden : !r_hidden;
        end else begin
            n_hidden = 1'b0;
        end
        if (r_all_bad) begin
            n_frame_out = 5'd0;
            n_dwell_out = w_is_tick ? DEFAULT_DWELL : 16'd0;
        end else if (w_is_tick) begin
            n_frame_out = r_ipxm;
            n_dwell_out = r_dwell;
        end else if (r_kind == KIND_HIDE) begin
            n_frame_out = r_hidden ? r_saved_index : 5'd0;
            n_dwell_out = 16'd0;
        end else begin
            n_frame_out = r_frame_index;
            n_dwell_out = (w_is_loop && w_total > 5'd1) ? START_DWELL : 16'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_count  <= 5'd0;
            r_start_frame  <= 5'd0;
            r_dwell_first  <= DEFAULT_DWELL;
            r_dwell_middle <= DEFAULT_DWELL;
            r_dwell_last   <= DEFAULT_DWELL;
            r_bad_frames   <= 32'd0;
            r_all_bad      <= 1'b0;
            r_configured   <= 1'b0;
            r_frame_index  <= 5'd0;
            r_saved_index  <= 5'd0;
            r_shown        <= 5'd0;
            r_dir_back     <= 1'b0;
            r_loop_mode    <= MODE_NONE;
            r_hidden       <= 1'b0;
            r_running      <= 1'b0;
            r_m_valid      <= 1'b0;
        end else begin
            if (i_cmd.cfg_we) begin
                case (i_cfg_index)
                    REG_FRAME_COUNT, REG_START_FRAME: begin
                        r_frame_count <= w_new_fc;
                        r_start_frame <= w_new_sf;
                        r_frame_index <= w_setup_idx;
                        r_hidden      <= 1'b0;
                        if (w_new_num == 5'd0) begin
                            r_shown <= 5'd0;
                        end
                        r_configured  <= 1'b1;
                    end
                    REG_DWELL_FIRST: begin
                        r_dwell_first <= i_cfg_data[15:0];
                        r_configured  <= 1'b1;
                    end
                    REG_DWELL_MIDDLE: begin
                        r_dwell_middle <= i_cfg_data[15:0];
                        r_configured   <= 1'b1;
                    end
                    REG_DWELL_LAST: begin
                        r_dwell_last <= i_cfg_data[15:0];
                        r_configured <= 1'b1;
                    end
                    REG_BAD_FRAMES: begin
                        r_bad_frames <= i_cfg_data;
                        r_configured <= 1'b1;
                    end
                    REG_ALL_BAD: begin
                        r_all_bad    <= i_cfg_data[0];
                        r_configured <= 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
            if (i_cmd.srch_start && i_cmd.srch_sel == SEL_CMD && w_is_loop) begin
                r_dir_back <= w_loop_dir;
            end
            if (i_cmd.decide) begin
                r_dir_back <= w_tick_dir;
            end
            if (i_cmd.save_index && w_srch_done) begin
                r_frame_index <= w_found;
            end
            if (i_cmd.finish) begin
                r_loop_mode <= n_loop_mode;
                r_running   <= n_running;
                r_hidden    <= n_hidden;
                r_shown     <= n_frame_out;
                if (r_kind == KIND_HIDE && !r_all_bad) begin
                    r_frame_index <= n_frame_out;
                    if (!r_hidden) begin
                        r_saved_index <= r_frame_index;
                    end
                end
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_kind   <= i_s_tuser;
            r_at_cur <= i_s_tdata[0];
        end
        if (i_cmd.save_first && w_srch_done) begin
            r_first <= w_found;
        end
        if (i_cmd.save_last && w_srch_done) begin
            r_last <= w_found;
        end
        if (i_cmd.decide) begin
            r_ipxm  <= r_frame_index;
            r_dwell <= w_tick_dwell;
        end
        if (i_cmd.finish) begin
            r_m_data <= {4'd0, n_hidden, n_running, n_dwell_out, w_total, n_frame_out};
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;

endmodule

// ----- design/fas_ctrl.sv -----
// Controller state machine: accepts requests and sequences searches and commit.
// Depends on fas_pkg.
module fas_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  fas_pkg::t_dp_stat i_stat,
    output fas_pkg::t_dp_cmd  o_cmd
);
    import fas_pkg::*;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_DISPATCH = 3'd1;
    localparam logic [2:0] S_FIRST    = 3'd2;
    localparam logic [2:0] S_LAST     = 3'd3;
    localparam logic [2:0] S_DECIDE   = 3'd4;
    localparam logic [2:0] S_NEXT     = 3'd5;
    localparam logic [2:0] S_CMD      = 3'd6;
    localparam logic [2:0] S_FINISH   = 3'd7;

    logic [2:0] r_state;
    logic [2:0] n_state;

    assign o_s_tready  = (r_state == S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE);

    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        o_cmd.cfg_we = i_cfg_valid && (r_state == S_IDLE);
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (i_stat.drop) begin
                    n_state = S_IDLE;
                end else if (i_stat.direct) begin
                    n_state = S_FINISH;
                end else if (i_stat.tick) begin
                    o_cmd.srch_start = 1'b1;
                    o_cmd.srch_sel   = SEL_FIRST;
                    n_state          = S_FIRST;
                end else begin
                    o_cmd.srch_start = 1'b1;
                    o_cmd.srch_sel   = SEL_CMD;
                    n_state          = S_CMD;
                end
            end
            S_FIRST: begin
                o_cmd.save_first = 1'b1;
                if (i_stat.srch_done) begin
                    o_cmd.srch_start = 1'b1;
                    o_cmd.srch_sel   = SEL_LAST;
                    n_state          = S_LAST;
                end
            end
            S_LAST: begin
                o_cmd.save_last = 1'b1;
                if (i_stat.srch_done) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                o_cmd.decide = 1'b1;
                if (i_stat.n_zero) begin
                    n_state = S_FINISH;
                end else begin
                    o_cmd.srch_start = 1'b1;
                    o_cmd.srch_sel   = SEL_NEXT;
                    n_state          = S_NEXT;
                end
            end
            S_NEXT, S_CMD: begin
                o_cmd.save_index = 1'b1;
                if (i_stat.srch_done) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (i_stat.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- design/frame_animation_sequencer.sv -----
// Top level of the frame animation sequencer: controller plus datapath.
// Depends on fas_pkg, fas_ctrl, fas_datapath and fas_search.
//
//  Channel   Dir  Handshake                 Carries
//  s         in   i_s_tvalid / o_s_tready   one request: kind and stop_at_current
//  m         out  o_m_tvalid / i_m_tready   one result: frame, totals, dwell, flags
//  cfg       in   i_cfg_valid / o_cfg_ready register index and write data
//
// Sequence: a request is not taken until the previous one has committed. Its bad-frame
//  searches run one after another in the shared search unit, one probe per cycle; a
//  search makes 1 to FRAMES+1 probes. A tick runs a first and a last search, a decide
//  state and, unless the loop is empty, a next search. Hide and all-bad requests skip the search.
// Reset: i_rst_n is synchronous and active low; configuration, loop state and valid flags return to their defaults.
// Stalls: the result sits in an output register; a new request is taken while it waits,
//  and the controller holds in its finish state only when a second result is ready.
module frame_animation_sequencer #(
    parameter int FRAMES = fas_pkg::FRAMES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [0] stop_at_current, [7:1] zero
    input  logic [3:0]  i_s_tuser,   // [3:0] kind
    // result stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // [4:0] frame, [9:5] frame_total, [25:10] dwell_ms,
                                     // [26] animating, [27] blank_shown, [31:28] zero
    // configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    import fas_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    // Sequence each request: dispatch, search, decide on ticks, then commit.
    fas_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    // Hold configuration and loop state; drive the result register.
    fas_datapath #(
        .FRAMES (FRAMES)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_s_tuser   (i_s_tuser),
        .i_s_tdata   (i_s_tdata),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)
    );

endmodule

// ----- design/fas_checker.sv -----
// Port-level checks for the frame animation sequencer, bound to the top level.
// Depends on frame_animation_sequencer_defines.svh.
`include "frame_animation_sequencer_defines.svh"

module fas_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [31:0] o_m_tdata
);

    `FAS_ASSERT_NEXT(a_out_hold, o_m_tvalid && !i_m_tready, o_m_tvalid, "result dropped")
    `FAS_ASSERT_NEXT(a_out_stable, o_m_tvalid && !i_m_tready, $stable(o_m_tdata), "result changed")
    `FAS_ASSERT_NOW(a_total_nonzero, o_m_tvalid, o_m_tdata[9:5] != 5'd0, "frame total zero")
    `FAS_ASSERT_NOW(a_frame_in_loop, o_m_tvalid, o_m_tdata[4:0] <= o_m_tdata[9:5], "frame past end")

endmodule

bind frame_animation_sequencer fas_checker u_fas_checker (.*);

// ----- tb/testbench.sv -----
// Self-checking bench for frame_animation_sequencer: directed and random requests,
// register writes between phases, random stalls on both streams, in-order result check.
// Depends on fas_pkg and the frame_animation_sequencer RTL only.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import fas_pkg::*;

    localparam int FRAMES        = FRAMES_DEF;
    localparam int SETTLE_CYCLES = 120;   // a tick runs three full searches
    localparam int HOLD_CYCLES   = 400;   // long receiver hold-off
    localparam int STALL_LIMIT   = 4000;  // cycles with no handshake at all
    localparam int TAIL_CYCLES   = 200;
    localparam int RANDOM_ITEMS  = 1275;
    localparam logic [3:0] KIND_SPARE_LAST = 4'd15;  // top of the unused kind codes

    // one result, the fields that the block packs into a result word
    typedef struct packed {
        logic [4:0]  frame;
        logic [4:0]  total;
        logic [15:0] dwell;
        logic        animating;
        logic        blank;
    } t_display;

    typedef enum logic [1:0] {OP_REQUEST, OP_WRITE, OP_SETTLE} t_op;

    typedef struct {
        t_op         op;
        logic [3:0]  kind;
        logic        at_cur;
        logic [2:0]  index;
        logic [31:0] data;
        logic        calm;      // no idling on either side
        logic        hold_rx;   // start the long receiver hold-off
    } t_pending;

    typedef enum logic [2:0] {
        DRV_FETCH, DRV_GAP, DRV_SEND, DRV_SETTLE, DRV_WRITE, DRV_DONE
    } t_drv_state;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;    // [0] stop_at_current, [7:1] zero
    logic [3:0]  s_tuser = '0;    // [3:0] kind
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;         // [4:0] frame, [9:5] frame_total, [25:10] dwell_ms,
                                  // [26] animating, [27] blank_shown, [31:28] zero
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;

    frame_animation_sequencer uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Sequencer model: registers, state and the results still owed
    // ------------------------------------------------------------------
    logic [4:0]  cfg_frames = '0;
    logic [4:0]  cfg_start = '0;
    logic [15:0] cfg_dwell_first = DEFAULT_DWELL;
    logic [15:0] cfg_dwell_mid = DEFAULT_DWELL;
    logic [15:0] cfg_dwell_last = DEFAULT_DWELL;
    logic [31:0] cfg_bad = '0;
    logic        cfg_all_bad = 1'b0;

    logic [4:0]  cur_index = '0;
    logic [4:0]  stash_index = '0;
    logic [4:0]  on_screen = '0;
    logic        going_back = 1'b0;
    logic [1:0]  play_mode = MODE_NONE;
    logic        blanked = 1'b0;
    logic        playing = 1'b0;
    logic        armed = 1'b0;

    t_display    displays_due[$];
    int          errors = 0;

    function automatic int unsigned live_frames();
        return (cfg_frames > FRAMES) ? FRAMES : cfg_frames;
    endfunction

    function automatic int unsigned shown_total();
        return (live_frames() == 0) ? 1 : live_frames();
    endfunction

    // wrap past the last frame back to the first
    function automatic int unsigned next_frame(input int unsigned p);
        return (p + 1 > live_frames()) ? p + 1 - shown_total() : p + 1;
    endfunction

    // wrap below the first frame; blank wraps to N-1
    function automatic int unsigned frame_before(input int unsigned p);
        int unsigned fst;
        fst = (live_frames() != 0) ? 1 : 0;
        return (p < fst + 1) ? p + shown_total() - 1 : p - 1;
    endfunction

    // circular hunt for a usable frame; blank when every probe is bad
    function automatic int unsigned find_good(input int unsigned from, input logic back);
        int unsigned p;
        p = (from > live_frames()) ? live_frames() : from;
        for (int i = 0; i <= FRAMES; i++) begin
            if (!(p < 32 && cfg_bad[p]))
                return p;
            p = back ? frame_before(p) : next_frame(p);
        end
        return 0;
    endfunction

    task automatic post_display(input int unsigned frame, input logic [15:0] dwell);
        t_display d;
        on_screen   = 5'(frame);
        d.frame     = 5'(frame);
        d.total     = 5'(shown_total());
        d.dwell     = dwell;
        d.animating = playing;
        d.blank     = blanked;
        displays_due.push_back(d);
    endtask

    // any register write arms the model; one that touches the loop size or start also resets the index
    task automatic apply_register(input logic [2:0] index, input logic [31:0] data);
        if (index <= REG_ALL_BAD)
            armed = 1'b1;
        case (index)
            REG_FRAME_COUNT:  cfg_frames = data[4:0];
            REG_START_FRAME:  cfg_start = data[4:0];
            REG_DWELL_FIRST:  cfg_dwell_first = data[15:0];
            REG_DWELL_MIDDLE: cfg_dwell_mid = data[15:0];
            REG_DWELL_LAST:   cfg_dwell_last = data[15:0];
            REG_BAD_FRAMES:   cfg_bad = data;
            REG_ALL_BAD:      cfg_all_bad = data[0];
            default: ;
        endcase
        if (index == REG_FRAME_COUNT || index == REG_START_FRAME) begin
            cur_index = (cfg_start >= 1 && cfg_start <= live_frames()) ? cfg_start : 5'd0;
            blanked = 1'b0;
            if (live_frames() == 0)
                on_screen = '0;
        end
    endtask

    // advance the model by one request; queue the display it causes, if any
    task automatic sequence_request(input logic [3:0] kind, input logic at_cur);
        int unsigned n, fst, lst, pos, lo_good, hi_good, p;
        logic [15:0] dwell;
        logic        keep;
        n = live_frames();
        fst = (n != 0) ? 1 : 0;
        lst = n;
        dwell = '0;
        if (!armed || kind > KIND_CURRENT)
            return;

        if (kind == KIND_TICK) begin
            if (!playing)
                return;
            if (cfg_all_bad) begin
                post_display(0, DEFAULT_DWELL);
                return;
            end
            pos = cur_index;
            lo_good = find_good(fst, 1'b0);
            hi_good = find_good(lst, 1'b1);
            dwell = DEFAULT_DWELL;
            case (play_mode)
                MODE_FWD: begin
                    dwell = (pos == lo_good) ? cfg_dwell_first :
                            (pos == hi_good) ? cfg_dwell_last : cfg_dwell_mid;
                    going_back = 1'b0;
                end
                MODE_BACK: begin
                    dwell = (pos == lo_good) ? cfg_dwell_last :
                            (pos == hi_good) ? cfg_dwell_first : cfg_dwell_mid;
                    going_back = 1'b1;
                end
                MODE_ROCK: begin
                    dwell = (pos == lo_good || pos == hi_good) ? cfg_dwell_last : cfg_dwell_mid;
                    if (pos == lo_good)
                        going_back = 1'b0;
                    else if (pos == hi_good)
                        going_back = 1'b1;
                end
                default: ;   // no mode: default dwell, keep the held direction
            endcase
            if (n != 0) begin
                p = going_back ? frame_before(cur_index) : next_frame(cur_index);
                cur_index = 5'(find_good(p, going_back));
            end
            post_display(pos, dwell);
            return;
        end

        case (kind)
            KIND_LOOP_FWD:  play_mode = MODE_FWD;
            KIND_LOOP_BACK: play_mode = MODE_BACK;
            KIND_ROCK:      play_mode = MODE_ROCK;
            default:        play_mode = MODE_NONE;
        endcase

        // every frame bad: show blank, keep the index, never arm the timer
        if (cfg_all_bad) begin
            if (kind == KIND_STOP)
                playing = 1'b0;
            if (kind != KIND_HIDE)
                blanked = 1'b0;
            post_display(0, '0);
            return;
        end

        case (kind)
            KIND_HIDE: begin
                if (!blanked) begin
                    stash_index = cur_index;
                    cur_index = '0;
                    blanked = 1'b1;
                end else begin
                    cur_index = stash_index;
                    blanked = 1'b0;
                end
            end
            KIND_STOP: begin
                playing = 1'b0;
                cur_index = 5'(at_cur ? find_good(on_screen, 1'b0) : find_good(lst, 1'b1));
            end
            KIND_STEP_FWD:  cur_index = 5'(find_good(next_frame(cur_index), 1'b0));
            KIND_STEP_BACK: cur_index = 5'(find_good(frame_before(cur_index), 1'b1));
            KIND_LOOP_FWD, KIND_LOOP_BACK, KIND_ROCK: begin
                keep = at_cur && ((kind == KIND_LOOP_BACK) ? on_screen != fst
                                                           : on_screen != lst);
                if (keep) begin
                    p = on_screen;
                end else if (kind == KIND_LOOP_BACK) begin
                    p = lst;
                    going_back = 1'b1;
                end else begin
                    p = fst;
                    going_back = 1'b0;
                end
                cur_index = 5'(find_good(p, going_back));
                // a loop of one frame or less never starts the timer
                if (shown_total() > 1) begin
                    playing = 1'b1;
                    dwell = START_DWELL;
                end
            end
            KIND_FIRST: cur_index = 5'(find_good(fst, 1'b0));
            KIND_LAST:  cur_index = 5'(find_good(lst, 1'b1));
            default:    cur_index = 5'(find_good(cur_index, 1'b0));
        endcase
        if (kind != KIND_HIDE)
            blanked = 1'b0;
        post_display(cur_index, dwell);
    endtask

    // ------------------------------------------------------------------
    // Stimulus list, filled once at time zero
    // ------------------------------------------------------------------
    t_pending    pending[$];
    logic        build_calm = 1'b0;
    logic        build_hold = 1'b0;

    task automatic queue_request(input logic [3:0] kind, input logic at_cur);
        t_pending t;
        t = '{OP_REQUEST, kind, at_cur, '0, '0, build_calm, build_hold};
        build_hold = 1'b0;
        pending.push_back(t);
    endtask

    task automatic queue_write(input logic [2:0] index, input logic [31:0] data);
        t_pending t;
        t = '{OP_WRITE, KIND_TICK, 1'b0, index, data, build_calm, 1'b0};
        pending.push_back(t);
    endtask

    task automatic queue_settle();
        t_pending t;
        t = '{OP_SETTLE, KIND_TICK, 1'b0, '0, '0, build_calm, 1'b0};
        pending.push_back(t);
    endtask

    function automatic logic [31:0] pick_frames();
        case ($urandom_range(0, 9))
            0:       return 0;
            1:       return 1;
            2:       return 31;
            3, 4:    return $urandom_range(0, 31);
            default: return $urandom_range(2, 8);
        endcase
    endfunction

    function automatic logic [31:0] pick_dwell();
        case ($urandom_range(0, 4))
            0:       return 0;
            1:       return 32'hFFFF;
            default: return $urandom_range(0, 65535);
        endcase
    endfunction

    function automatic logic [31:0] pick_bad();
        case ($urandom_range(0, 9))
            5, 6, 7: return $urandom & $urandom & $urandom;   // a few holes
            8:       return '1;
            9:       return $urandom;
            default: return '0;
        endcase
    endfunction

    // rewrite a random subset of registers; a hold-off phase needs a running loop
    task automatic queue_random_setup(input logic write_all, input logic hold_phase);
        if (hold_phase)
            queue_write(REG_FRAME_COUNT, 16);
        else if (write_all || $urandom_range(0, 1))
            queue_write(REG_FRAME_COUNT, pick_frames());
        if (write_all || $urandom_range(0, 2) == 0)
            queue_write(REG_START_FRAME, $urandom_range(0, 31));
        if (write_all || $urandom_range(0, 1))
            queue_write(REG_DWELL_FIRST, pick_dwell());
        if (write_all || $urandom_range(0, 1))
            queue_write(REG_DWELL_MIDDLE, pick_dwell());
        if (write_all || $urandom_range(0, 1))
            queue_write(REG_DWELL_LAST, pick_dwell());
        if (write_all || $urandom_range(0, 1))
            queue_write(REG_BAD_FRAMES, hold_phase ? '0 : pick_bad());
        if (hold_phase)
            queue_write(REG_ALL_BAD, 0);
        else if (write_all || $urandom_range(0, 2) == 0)
            queue_write(REG_ALL_BAD, ($urandom_range(0, 9) == 0) ? 1 : 0);
    endtask

    // ------------------------------------------------------------------
    // Request and register driver: changes inputs on the falling edge
    // ------------------------------------------------------------------
    t_drv_state  drv_state = DRV_FETCH;
    t_pending    cur_item;
    int          gap_cnt = 0;
    int          settle_cnt = 0;
    logic        req_taken = 1'b0;      // handshakes seen at the last rising edge
    logic        write_taken = 1'b0;
    logic        result_taken = 1'b0;
    logic        rx_calm = 1'b0;
    int          holds_asked = 0;

    always @(negedge clk) begin
        if (rst_n && drv_state != DRV_DONE) begin
            // retire what the last rising edge accepted
            if (drv_state == DRV_SEND && req_taken)
                drv_state = DRV_FETCH;
            if (drv_state == DRV_WRITE && write_taken)
                drv_state = DRV_FETCH;
            // pause until every result is in, then let the block drain silent work
            if (drv_state == DRV_SETTLE) begin
                if (displays_due.size() != 0)
                    settle_cnt = SETTLE_CYCLES;
                else if (settle_cnt == 0)
                    drv_state = (cur_item.op == OP_WRITE) ? DRV_WRITE : DRV_FETCH;
                else
                    settle_cnt--;
            end
            if (drv_state == DRV_GAP) begin
                if (gap_cnt == 0)
                    drv_state = DRV_SEND;
                else
                    gap_cnt--;
            end
            if (drv_state == DRV_FETCH) begin
                if (pending.size() == 0) begin
                    drv_state = DRV_DONE;
                end else begin
                    cur_item = pending.pop_front();
                    if (cur_item.hold_rx)
                        holds_asked <= holds_asked + 1;
                    if (cur_item.op == OP_REQUEST) begin
                        gap_cnt = cur_item.calm ? 0 : $urandom_range(0, 11);
                        drv_state = (gap_cnt == 0) ? DRV_SEND : DRV_GAP;
                    end else begin
                        settle_cnt = SETTLE_CYCLES;
                        drv_state = DRV_SETTLE;
                    end
                end
            end
            rx_calm   <= cur_item.calm;
            s_tvalid  <= (drv_state == DRV_SEND);
            s_tuser   <= cur_item.kind;
            s_tdata   <= {7'b0, cur_item.at_cur};
            cfg_valid <= (drv_state == DRV_WRITE);
            cfg_index <= cur_item.index;
            cfg_data  <= cur_item.data;
        end else if (rst_n) begin
            s_tvalid  <= 1'b0;
            cfg_valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Result receiver: random stall after each result, long hold-off on demand
    // ------------------------------------------------------------------
    int          holds_done = 0;
    int          rx_wait = 0;

    always @(negedge clk) begin
        if (rst_n) begin
            if (holds_done != holds_asked) begin
                holds_done = holds_asked;
                rx_wait = HOLD_CYCLES;
            end else if (result_taken) begin
                rx_wait = rx_calm ? 0 : $urandom_range(0, 11);
            end else if (rx_wait != 0) begin
                rx_wait--;
            end
            m_tready <= (rx_wait == 0);
        end
    end

    // ------------------------------------------------------------------
    // Monitor: sample handshakes on the rising edge, predict and compare
    // ------------------------------------------------------------------
    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    int          quiet_cycles = 0;
    t_display    want;

    always @(posedge clk) begin
        if (rst_n) begin
            req_taken    <= s_tvalid && s_tready;
            write_taken  <= cfg_valid && cfg_ready;
            result_taken <= m_tvalid && m_tready;

            // compare first: a result accepted now belongs to an older request
            if (m_tvalid && m_tready) begin
                if (displays_due.size() == 0) begin
                    $error("result with nothing pending: tdata %h", m_tdata);
                    errors++;
                end else begin
                    want = displays_due.pop_front();
                    check_field("frame", 32'(want.frame), 32'(m_tdata[4:0]));
                    check_field("frame_total", 32'(want.total), 32'(m_tdata[9:5]));
                    check_field("dwell_ms", 32'(want.dwell), 32'(m_tdata[25:10]));
                    check_field("animating", 32'(want.animating), 32'(m_tdata[26]));
                    check_field("blank_shown", 32'(want.blank), 32'(m_tdata[27]));
                end
            end
            if (s_tvalid && s_tready)
                sequence_request(s_tuser, s_tdata[0]);
            if (cfg_valid && cfg_ready)
                apply_register(cfg_index, cfg_data);

            // watchdog: any handshake counts as progress
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $error("no handshake for %0d cycles", STALL_LIMIT);
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Build the stimulus, release reset, wait for the end
    // ------------------------------------------------------------------
    initial begin
        int items;
        int phase;
        int phase_items;
        int r;
        logic hold_phase;

        // requests before any register write: all ignored
        queue_request(KIND_TICK, 1'b0);
        queue_request(KIND_LOOP_FWD, 1'b1);
        queue_request(KIND_SPARE_LAST, 1'b1);

        // full loop, extreme dwells, no bad frames
        queue_write(REG_FRAME_COUNT, 31);
        queue_write(REG_START_FRAME, 31);
        queue_write(REG_DWELL_FIRST, 0);
        queue_write(REG_DWELL_MIDDLE, 32'hFFFF);
        queue_write(REG_DWELL_LAST, 1);
        queue_write(REG_BAD_FRAMES, 0);
        queue_write(REG_ALL_BAD, 0);
        queue_request(KIND_CURRENT, 1'b0);
        queue_request(KIND_STEP_FWD, 1'b0);     // wrap past the last frame
        queue_request(KIND_STEP_BACK, 1'b0);    // wrap below the first frame
        queue_request(KIND_HIDE, 1'b0);
        queue_request(KIND_STEP_BACK, 1'b1);    // back step from blank
        queue_request(KIND_LOOP_FWD, 1'b0);
        queue_request(KIND_TICK, 1'b0);
        queue_request(KIND_TICK, 1'b1);
        queue_request(KIND_ROCK, 1'b1);
        queue_request(KIND_TICK, 1'b0);
        queue_request(KIND_LOOP_BACK, 1'b0);
        queue_request(KIND_TICK, 1'b0);
        queue_request(KIND_FIRST, 1'b0);        // non-loop command while running
        queue_request(KIND_TICK, 1'b0);
        queue_request(KIND_STOP, 1'b1);
        queue_request(KIND_TICK, 1'b0);         // not running: ignored
        queue_request(4'(KIND_CURRENT + 1), 1'b1);
        queue_request(KIND_LAST, 1'b0);
        queue_settle();

        // shrink the loop under the shown frame, start out of range, holes
        queue_write(REG_FRAME_COUNT, 5);
        queue_write(REG_BAD_FRAMES, 32'h0000_0016);
        queue_request(KIND_STOP, 1'b1);         // shown frame beyond N
        queue_request(KIND_STEP_FWD, 1'b0);
        queue_request(KIND_LOOP_BACK, 1'b1);
        queue_write(REG_BAD_FRAMES, '1);        // every probe fails
        queue_request(KIND_TICK, 1'b0);
        queue_request(KIND_STEP_BACK, 1'b0);
        queue_write(REG_ALL_BAD, 1);
        queue_request(KIND_LOOP_FWD, 1'b0);
        queue_request(KIND_HIDE, 1'b0);
        queue_request(KIND_TICK, 1'b0);
        queue_request(KIND_STOP, 1'b0);
        queue_write(REG_ALL_BAD, 0);
        queue_write(REG_BAD_FRAMES, 0);
        queue_write(REG_FRAME_COUNT, 0);
        queue_request(KIND_LOOP_FWD, 1'b0);     // loop of zero frames does not run
        queue_write(REG_FRAME_COUNT, 1);
        queue_request(KIND_ROCK, 1'b0);

        // random phases: mostly loops driven by ticks, some commands, a little noise
        items = 0;
        phase = 0;
        while (items < RANDOM_ITEMS) begin
            hold_phase = (phase == 1 || phase == 5);
            build_calm = ($urandom_range(0, 3) == 0);
            queue_random_setup(phase == 0, hold_phase);
            build_hold = hold_phase;
            phase_items = $urandom_range(60, 120);
            while (phase_items > 0) begin
                r = $urandom_range(0, 99);
                if (r < 12 || build_hold) begin
                    queue_request(4'(KIND_LOOP_FWD + $urandom_range(0, 2)),
                                  1'($urandom_range(0, 1)));
                    repeat ($urandom_range(2, 16)) begin
                        queue_request(KIND_TICK, 1'($urandom_range(0, 1)));
                        phase_items--;
                        items++;
                    end
                end else if (r < 70) begin
                    queue_request(KIND_TICK, 1'($urandom_range(0, 1)));
                end else if (r < 95) begin
                    queue_request(4'($urandom_range(KIND_HIDE, KIND_CURRENT)),
                                  1'($urandom_range(0, 1)));
                end else begin
                    queue_request(4'($urandom_range(KIND_CURRENT + 1, KIND_SPARE_LAST)),
                                  1'($urandom_range(0, 1)));
                    phase_items++;
                    items--;
                end
                if ($urandom_range(0, 49) == 0)
                    queue_settle();
                phase_items--;
                items++;
            end
            queue_settle();
            phase++;
        end

        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        while (drv_state != DRV_DONE || displays_due.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
